@@ rtl/core/planar_rle24_pixel_decoder_macros.svh @@
// Assertion helpers for the planar run-length decoder.
`ifndef PLANAR_RLE24_PIXEL_DECODER_MACROS_SVH
`define PLANAR_RLE24_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/prl_pkg.sv @@
package prl_pkg;

  // Parser modes
  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;

  // Channel codes
  localparam logic [1:0] CH_RED  = 2'd0;
  localparam logic [1:0] CH_BLUE = 2'd2;

  localparam logic [14:0] PIXEL_COUNT_RESET = 15'd16384;
  localparam logic [7:0]  REPEAT_BIAS       = 8'd125;
  localparam logic [2:0]  PREFIX_LEN        = 3'd4;

  // Byte handed from the front stage to the decoder
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;   // reset decoder state, no byte to decode
    logic       decode;    // run data_byte through the parser
  } prl_req_t;

  // One decoded span
  typedef struct packed {
    logic [1:0]  channel;
    logic [13:0] first_pixel;
    logic [7:0]  span_length;
    logic [7:0]  value;
    logic        plane_end;
    logic        image_done;
  } prl_span_t;

endpackage

@@ rtl/core/planar_rle24_pixel_decoder.sv @@
// Datapath: an accepted byte is registered in the front stage, then decoded into a
// two-entry output buffer.
// Throughput: one byte per cycle unless the output stalls; a nonzero four-byte stream
// prefix is replayed through the decoder while the input is held.
// Reset: asynchronous, active low; pixel_count returns to 16384 and decoding restarts.
`include "planar_rle24_pixel_decoder_macros.svh"

module planar_rle24_pixel_decoder #(
  parameter int MAX_PIXELS = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,    // pixel_count
  // compressed byte requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_of_stream
  // span requests
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [13:0] first_pixel, [21:14] span_length,
                                      // [29:22] value, [31:30] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] channel, [2] image_done
  output logic        m_axis_tlast    // plane_end
);
  import prl_pkg::*;

  logic      req_valid, req_ready;
  prl_req_t  req;
  logic      span_valid, span_ready;
  prl_span_t span, out_span;

  // Prefix hold and replay
  prl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_byte_i    (s_axis_tdata),
    .s_sos_i     (s_axis_tuser[0]),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  // Run parser and span generator
  prl_decode #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .req_ready_o  (req_ready),
    .span_valid_o (span_valid),
    .span_o       (span),
    .span_ready_i (span_ready)
  );

  // Output buffer
  prl_span_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (span_valid),
    .wr_ready_o (span_ready),
    .wr_data_i  (span),
    .rd_valid_o (m_axis_tvalid),
    .rd_ready_i (m_axis_tready),
    .rd_data_o  (out_span)
  );

  // Pack output fields
  assign m_axis_tdata = {2'b00, out_span.value, out_span.span_length, out_span.first_pixel};
  assign m_axis_tuser = {out_span.image_done, out_span.channel};
  assign m_axis_tlast = out_span.plane_end;

  `PRL_ASSERT_IMPLIES(a_done_on_blue_end, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast && (m_axis_tuser[1:0] == CH_BLUE), "image_done without blue plane end")
  `PRL_ASSERT_IMPLIES(a_span_not_empty, m_axis_tvalid, m_axis_tdata[21:14] != 8'd0, "empty span")
  `PRL_ASSERT_NEXT(a_cfg_flushes_front, cfg_we_i, !req_valid, "front request survived a config write")

endmodule

@@ rtl/core/prl_front.sv @@
module prl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [7:0]         s_byte_i,
  input  logic               s_sos_i,
  output logic               req_valid_o,
  output prl_pkg::prl_req_t  req_o,
  input  logic               req_ready_i
);
  import prl_pkg::*;

  logic [7:0] prefix_q [4];
  logic [2:0] pc_q, pc_d, pc_eff;
  logic       replay_q, replay_d;
  logic [1:0] idx_q, idx_d;
  logic       req_valid_q, req_valid_d;
  prl_req_t   req_q, req_d;
  logic       adv, accept, complete, nonzero;

  // Request register advances when empty or drained
  assign adv       = !req_valid_q || req_ready_i;
  assign s_ready_o = adv && !replay_q;
  assign accept    = s_valid_i && s_ready_o;

  // Prefix position as seen by this byte
  assign pc_eff   = s_sos_i ? 3'd0 : pc_q;
  assign complete = (pc_eff == PREFIX_LEN - 3'd1);
  assign nonzero  = |(prefix_q[0] | prefix_q[1] | prefix_q[2] | s_byte_i);

  always_comb begin
    pc_d        = pc_q;
    replay_d    = replay_q;
    idx_d       = idx_q;
    req_valid_d = req_valid_q;
    req_d       = req_q;
    if (cfg_we_i) begin
      pc_d        = 3'd0;
      replay_d    = 1'b0;
      req_valid_d = 1'b0;
    end else if (adv) begin
      req_valid_d = 1'b0;
      if (replay_q) begin
        // replay held prefix bytes one per cycle while the request register advances
        req_valid_d = 1'b1;
        req_d       = '{data_byte: prefix_q[idx_q], restart: 1'b0, decode: 1'b1};
        idx_d       = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          replay_d = 1'b0;
        end
      end else if (accept) begin
        req_valid_d = 1'b1;
        if (pc_eff[2]) begin
          req_d = '{data_byte: s_byte_i, restart: 1'b0, decode: 1'b1};
        end else begin
          pc_d = pc_eff + 3'd1;
          if (complete && nonzero) begin
            req_d    = '{data_byte: prefix_q[0], restart: 1'b0, decode: 1'b1};
            replay_d = 1'b1;
            idx_d    = 2'd1;
          end else begin
            req_d = '{data_byte: s_byte_i, restart: s_sos_i, decode: 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= 3'd0;
      replay_q    <= 1'b0;
      idx_q       <= 2'd0;
      req_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      replay_q    <= replay_d;
      idx_q       <= idx_d;
      req_valid_q <= req_valid_d;
    end
  end

  // Payload: request data and prefix store
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (accept && !pc_eff[2]) begin
      prefix_q[pc_eff[1:0]] <= s_byte_i;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

@@ rtl/core/prl_decode.sv @@
module prl_decode #(
  parameter int MAX_PIXELS = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               req_valid_i,
  input  prl_pkg::prl_req_t  req_i,
  output logic               req_ready_o,
  output logic               span_valid_o,
  output prl_pkg::prl_span_t span_o,
  input  logic               span_ready_i
);
  import prl_pkg::*;

  localparam int PosW = $clog2(MAX_PIXELS + 1);
  localparam int XW   = ((PosW > 14) ? PosW : 14) + 1;
  localparam logic [XW-1:0] MaxX = XW'(MAX_PIXELS);

  logic [14:0]     pixel_count_q, pixel_count_d;
  logic [1:0]      plane_q, plane_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      mode_q, mode_d;
  logic [7:0]      lit_q, lit_d, lit_dec;
  logic [7:0]      rep_q, rep_d;
  logic            fin_q, fin_d;

  logic [XW-1:0] cnt_x, cfg_x, eff_x, eff_cfg_x, pos_x, rep_x, room_x, len_x, sum_x;
  logic          fire, emit, span_end;
  logic [7:0]    val;

  // Saturate the pixel count to the configured maximum
  assign cnt_x     = XW'(pixel_count_q);
  assign cfg_x     = XW'(cfg_wdata_i);
  assign eff_x     = (cnt_x > MaxX) ? MaxX : cnt_x;
  assign eff_cfg_x = (cfg_x > MaxX) ? MaxX : cfg_x;
  assign pos_x     = XW'(pos_q);
  assign rep_x     = XW'(rep_q);
  assign room_x    = eff_x - pos_x;
  assign lit_dec   = lit_q - 8'd1;

  assign fire        = req_valid_i && span_ready_i;
  assign req_ready_o = span_ready_i;

  always_comb begin
    pixel_count_d = pixel_count_q;
    plane_d       = plane_q;
    pos_d         = pos_q;
    mode_d        = mode_q;
    lit_d         = lit_q;
    rep_d         = rep_q;
    fin_d         = fin_q;
    emit          = 1'b0;
    len_x         = '0;
    val           = req_i.data_byte;
    sum_x         = pos_x;
    span_end      = 1'b0;

    if (cfg_we_i) begin
      // new count, fresh stream
      pixel_count_d = cfg_wdata_i;
      plane_d       = CH_RED;
      pos_d         = '0;
      mode_d        = MODE_HEADER;
      lit_d         = 8'd0;
      rep_d         = 8'd0;
      fin_d         = (eff_cfg_x == '0);
    end else if (fire && req_i.restart) begin
      plane_d = CH_RED;
      pos_d   = '0;
      mode_d  = MODE_HEADER;
      lit_d   = 8'd0;
      rep_d   = 8'd0;
      fin_d   = (eff_x == '0);
    end else if (fire && req_i.decode && !fin_q) begin
      // parse one byte
      unique case (mode_q)
        MODE_LITERAL: begin
          lit_d  = lit_dec;
          mode_d = (lit_dec == 8'd0) ? MODE_HEADER : MODE_LITERAL;
          emit   = 1'b1;
          len_x  = XW'(1);
        end
        MODE_REPEAT: begin
          mode_d = MODE_HEADER;
          emit   = 1'b1;
          len_x  = (rep_x < room_x) ? rep_x : room_x;
        end
        default: begin
          if (!req_i.data_byte[7]) begin
            lit_d  = req_i.data_byte + 8'd1;
            mode_d = MODE_LITERAL;
          end else begin
            rep_d  = req_i.data_byte - REPEAT_BIAS;
            mode_d = MODE_REPEAT;
          end
        end
      endcase

      // span bookkeeping, cut at plane end
      if (emit) begin
        sum_x    = pos_x + len_x;
        span_end = (sum_x >= eff_x);
        pos_d    = PosW'(sum_x);
        if (span_end) begin
          pos_d  = '0;
          mode_d = MODE_HEADER;
          lit_d  = 8'd0;
          if (plane_q == CH_BLUE) begin
            plane_d = CH_RED;
            fin_d   = 1'b1;
          end else begin
            plane_d = plane_q + 2'd1;
          end
        end
      end
    end
  end

  assign span_valid_o       = emit;
  assign span_o.channel     = plane_q;
  assign span_o.first_pixel = pos_x[13:0];
  assign span_o.span_length = len_x[7:0];
  assign span_o.value       = val;
  assign span_o.plane_end   = span_end;
  assign span_o.image_done  = span_end && (plane_q == CH_BLUE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= PIXEL_COUNT_RESET;
      plane_q       <= CH_RED;
      pos_q         <= '0;
      mode_q        <= MODE_HEADER;
      lit_q         <= 8'd0;
      rep_q         <= 8'd0;
      fin_q         <= 1'b0;
    end else begin
      pixel_count_q <= pixel_count_d;
      plane_q       <= plane_d;
      pos_q         <= pos_d;
      mode_q        <= mode_d;
      lit_q         <= lit_d;
      rep_q         <= rep_d;
      fin_q         <= fin_d;
    end
  end

endmodule

@@ rtl/core/prl_span_fifo.sv @@
module prl_span_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  prl_pkg::prl_span_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output prl_pkg::prl_span_t rd_data_o
);
  import prl_pkg::*;

  prl_span_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // Two-entry skid between decoder and output port
  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
